FILE: src/matrix_inverse_2x2_top_assert.svh
// assertion macros shared by the checker of the 2x2 matrix inverse
// depends on nothing; the user supplies clk and arst_n in scope
`ifndef MATRIX_INVERSE_2X2_TOP_ASSERT_SVH
`define MATRIX_INVERSE_2X2_TOP_ASSERT_SVH

// same-cycle implication under reset
`define MI2_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mi2 implication check failed");

// next-cycle implication under reset
`define MI2_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mi2 next-cycle check failed");

`endif

FILE: src/mi2_pkg.sv
// shared types and constants of the 2x2 matrix inverse pipeline
// no dependencies
package mi2_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NLANE = 4;
	localparam int QW = 32;
	localparam int DW = 64;
	// running remainder: below den * 2^32 with den under 2^63
	localparam int RW = 96;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [QW-1:0] q;
	} lane_t;

	typedef struct packed {
		logic signed [DW-1:0] det;
		logic [DW-1:0] den;
		logic sing;
		logic ssat;
		logic [NLANE-1:0] neg;
		logic [NLANE-1:0] ovf;
		logic [NLANE-1:0][QW-1:0] sr;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [NLANE-1:0][QW-1:0] num;
	} front_t;

endpackage

FILE: src/mi2_det.sv
// front end: products, determinant, adjugate magnitudes and range checks
// depends on mi2_pkg
module mi2_det #(
	parameter int FRAC_BITS = mi2_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic [2:0] en,
	input  logic signed [31:0] m00,
	input  logic signed [31:0] m01,
	input  logic signed [31:0] m10,
	input  logic signed [31:0] m11,
	output mi2_pkg::front_t front
);
	import mi2_pkg::*;

	localparam int SH = 2 * FRAC_BITS;

	logic signed [DW-1:0] ad_s1, bc_s1;
	logic signed [31:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [DW-1:0] det_s2;
	logic signed [32:0] adj_s2 [NLANE];
	front_t front_s3;
	front_t fr;
	logic [DW-1:0] den;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ad_s1 <= DW'(m00) * DW'(m11);
			bc_s1 <= DW'(m01) * DW'(m10);
			a_s1 <= m00;
			b_s1 <= m01;
			c_s1 <= m10;
			d_s1 <= m11;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			det_s2 <= ad_s1 - bc_s1;
			adj_s2[0] <= 33'(d_s1);
			adj_s2[1] <= -(33'(b_s1));
			adj_s2[2] <= -(33'(c_s1));
			adj_s2[3] <= 33'(a_s1);
		end
	end

	always_comb begin
		den = det_s2[DW-1] ? DW'(-det_s2) : DW'(det_s2);
		fr.side.det = det_s2;
		fr.side.den = den;
		fr.side.sing = (det_s2 == '0);
		fr.side.ssat = 1'b0;
		for (int k = 0; k < NLANE; k++) begin
			fr.num[k] = adj_s2[k][32] ? QW'(-adj_s2[k]) : QW'(adj_s2[k]);
			fr.side.neg[k] = (adj_s2[k][32] != det_s2[DW-1]) && (adj_s2[k] != '0);
			// quotient of 2^32 or more
			fr.side.ovf[k] = ((RW'(fr.num[k]) << SH) >= (RW'(den) << QW));
			// only the negation of the most negative entry leaves range
			if (adj_s2[k] > 33'sh0_7fff_ffff) begin
				fr.side.sr[k] = 32'h7fff_ffff;
				fr.side.ssat = 1'b1;
			end else begin
				fr.side.sr[k] = adj_s2[k][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			front_s3 <= fr;
		end
	end

	assign front = front_s3;

endmodule

FILE: src/mi2_div_step.sv
// one restoring division step of one lane, registered
// depends on mi2_pkg
module mi2_div_step #(
	parameter int BIT = 31
) (
	input  logic clk,
	input  logic en,
	input  logic [mi2_pkg::DW-1:0] den,
	input  mi2_pkg::lane_t lane_in,
	output mi2_pkg::lane_t lane_next
);
	import mi2_pkg::*;

	logic [RW-1:0] trial;
	logic ge;
	lane_t nxt;
	lane_t lane_s;

	always_comb begin
		trial = RW'(den) << BIT;
		ge = (lane_in.r >= trial);
		nxt.r = ge ? (lane_in.r - trial) : lane_in.r;
		nxt.q = lane_in.q;
		nxt.q[BIT] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s <= nxt;
		end
	end

	assign lane_next = lane_s;

endmodule

FILE: src/matrix_inverse_2x2_top.sv
// 2x2 matrix inverse, top level: pipeline control, divider lanes, output stage
// depends on mi2_pkg, mi2_det, mi2_div_step
//
// takes one 2x2 matrix [m00 m01; m10 m11] in signed fixed point with FRAC_BITS
// fraction bits per cycle and returns det (exact, 2*FRAC_BITS fraction bits) and
// the inverse: each adjugate entry times 2^(2*FRAC_BITS) divided by det, truncated
// toward zero and clamped to 32 bits, with saturated set on any clamp. a zero det
// gives the adjugate unscaled with singular set. the pipeline has three
// front-end stages (products, determinant, magnitudes and overflow check), 32
// restoring divide stages for four parallel lanes and one output stage. an item
// may enter every cycle; each stage holds only when the one after it is full
// and held, so bubbles close up under a stalled output.
module matrix_inverse_2x2_top #(
	parameter int FRAC_BITS = mi2_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] m00,
	input  logic signed [31:0] m01,
	input  logic signed [31:0] m10,
	input  logic signed [31:0] m11,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] inv00,
	output logic signed [31:0] inv01,
	output logic signed [31:0] inv10,
	output logic signed [31:0] inv11,
	output logic signed [63:0] det,
	output logic singular,
	output logic saturated
);
	import mi2_pkg::*;

	localparam int SH = 2 * FRAC_BITS;
	localparam int NFE = 3;
	localparam int NDIV = QW;
	localparam int NS = NFE + NDIV + 1;

	typedef struct packed {
		logic [NLANE-1:0][QW-1:0] inv;
		logic signed [DW-1:0] det;
		logic sing;
		logic sat;
	} res_t;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;
	front_t front;
	side_t side_q [NDIV];
	lane_t lane_w [NDIV][NLANE];
	res_t res;
	res_t res_s36;

	// stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NS-1] = !v_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];
	assign out_valid = v_q[NS-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	mi2_det #(.FRAC_BITS(FRAC_BITS)) u_det (
		.clk(clk),
		.en(en[2:0]),
		.m00(m00),
		.m01(m01),
		.m10(m10),
		.m11(m11),
		.front(front)
	);

	// sideband for the divide stages: det, flags and singular results
	always_ff @(posedge clk) begin
		if (en[NFE]) begin
			side_q[0] <= front.side;
		end
		for (int j = 1; j < NDIV; j++) begin
			if (en[NFE+j]) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// divide lanes, one quotient bit per stage, msb first
	for (genvar j = 0; j < NDIV; j++) begin : g_step
		for (genvar k = 0; k < NLANE; k++) begin : g_lane
			lane_t lin;
			logic [DW-1:0] dn;
			if (j == 0) begin : g_first
				assign lin.r = RW'(front.num[k]) << SH;
				assign lin.q = '0;
				assign dn = front.side.den;
			end else begin : g_rest
				assign lin = lane_w[j-1][k];
				assign dn = side_q[j-1].den;
			end
			mi2_div_step #(.BIT(QW - 1 - j)) u_step (
				.clk(clk),
				.en(en[NFE+j]),
				.den(dn),
				.lane_in(lin),
				.lane_next(lane_w[j][k])
			);
		end
	end

	// sign, clamp and singular select
	always_comb begin
		logic [QW-1:0] q;
		side_t sd;
		sd = side_q[NDIV-1];
		res.det = sd.det;
		res.sing = sd.sing;
		res.sat = sd.sing ? sd.ssat : 1'b0;
		for (int k = 0; k < NLANE; k++) begin
			q = lane_w[NDIV-1][k].q;
			if (sd.sing) begin
				res.inv[k] = sd.sr[k];
			end else if (sd.neg[k]) begin
				if (sd.ovf[k] || (q > 32'h8000_0000)) begin
					res.inv[k] = 32'h8000_0000;
					res.sat = 1'b1;
				end else begin
					res.inv[k] = -q;
				end
			end else begin
				if (sd.ovf[k] || q[QW-1]) begin
					res.inv[k] = 32'h7fff_ffff;
					res.sat = 1'b1;
				end else begin
					res.inv[k] = q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res_s36 <= res;
		end
	end

	assign inv00 = res_s36.inv[0];
	assign inv01 = res_s36.inv[1];
	assign inv10 = res_s36.inv[2];
	assign inv11 = res_s36.inv[3];
	assign det = res_s36.det;
	assign singular = res_s36.sing;
	assign saturated = res_s36.sat;

endmodule

FILE: src/mi2_checker.sv
// port-level checks of the 2x2 matrix inverse, bound to the top level
// depends on matrix_inverse_2x2_top_assert.svh
module mi2_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic signed [31:0] m00,
	input logic signed [31:0] m01,
	input logic signed [31:0] m10,
	input logic signed [31:0] m11,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] inv00,
	input logic signed [31:0] inv01,
	input logic signed [31:0] inv10,
	input logic signed [31:0] inv11,
	input logic signed [63:0] det,
	input logic singular,
	input logic saturated
);
`include "matrix_inverse_2x2_top_assert.svh"

	// singular flag matches a zero determinant
	`MI2_ASSERT_IMPLY(a_sing_det, out_valid && singular, det == 64'sd0)
	`MI2_ASSERT_IMPLY(a_det_sing, out_valid && (det == 64'sd0), singular)
	// a saturated singular result comes only from negating the most negative entry
	`MI2_ASSERT_IMPLY(a_sing_sat, out_valid && singular && saturated, (inv01 == 32'sh7fff_ffff) || (inv10 == 32'sh7fff_ffff))
	// a held result stays valid and keeps its det and inv00
	`MI2_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(det) && $stable(inv00))

endmodule

bind matrix_inverse_2x2_top mi2_checker u_mi2_checker (.*);

FILE: sim/testbench.sv
// self-checking bench for the 2x2 matrix inverse pipeline
// depends on matrix_inverse_2x2_top and mi2_pkg; no files, no arguments
// a directed table then random matrices, checked against an in-bench model
module testbench;

	// one inverse as the block returns it
	typedef struct {
		logic signed [31:0] i00, i01, i10, i11;
		logic signed [63:0] d;
		logic sing;
		logic sat;
	} inverse_t;

	// one row of the directed table: matrix, and optionally a typed-in answer
	typedef struct {
		logic signed [31:0] a, b, c, d;
		bit typed;
		inverse_t ans;
	} row_t;

	localparam int FB = mi2_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM = 2000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] m00, m01, m10, m11;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] inv00, inv01, inv10, inv11;
	logic signed [63:0] det;
	logic singular;
	logic saturated;

	inverse_t pending_inverses[$];
	int errors = 0;
	bit sending_done = 0;

	matrix_inverse_2x2_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.m00(m00), .m01(m01), .m10(m10), .m11(m11),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv00(inv00), .inv01(inv01), .inv10(inv10), .inv11(inv11),
		.det(det), .singular(singular), .saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// adj * 2^(2*FB) / det, truncated toward zero and clamped to 32 bits
	function automatic longint scaled_quotient(longint adj, longint dv, ref bit sat);
		logic [127:0] num, den, q;
		bit neg;
		neg = ((adj < 0) != (dv < 0)) && adj != 0;
		num = (adj < 0) ? 128'(-adj) : 128'(adj);
		den = (dv < 0) ? 128'(64'(-dv)) : 128'(64'(dv));
		num = num << (2 * FB);
		q = num / den;
		if (neg) begin
			if (q > 128'd2147483648) begin
				sat = 1;
				return S32_MIN;
			end
			return -longint'(q);
		end
		if (q > 128'd2147483647) begin
			sat = 1;
			return S32_MAX;
		end
		return longint'(q);
	endfunction

	// full expected result for one matrix
	function automatic inverse_t inverse_of(logic signed [31:0] a, b, c, d);
		inverse_t r;
		longint dv, adj[4], v[4];
		bit sat;
		sat = 0;
		dv = longint'(a) * longint'(d) - longint'(b) * longint'(c);
		adj[0] = d;
		adj[1] = -longint'(b);
		adj[2] = -longint'(c);
		adj[3] = a;
		for (int k = 0; k < 4; k++) begin
			if (dv == 0) begin
				// singular: adjugate unscaled, only -2^31 negated can clamp
				v[k] = adj[k];
				if (v[k] > S32_MAX) begin
					v[k] = S32_MAX;
					sat = 1;
				end
			end else
				v[k] = scaled_quotient(adj[k], dv, sat);
		end
		r.i00 = v[0][31:0];
		r.i01 = v[1][31:0];
		r.i10 = v[2][31:0];
		r.i11 = v[3][31:0];
		r.d = dv;
		r.sing = (dv == 0);
		r.sat = sat;
		return r;
	endfunction

	// entry value: extremes, zero, small Q16.16 numbers or anything at all
	function automatic logic signed [31:0] pick_entry();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return 32'sd0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	// directed matrices; typed answers only where obvious
	row_t directed[$];
	initial begin
		row_t r;
		r = '{a: ONE, b: 0, c: 0, d: ONE, typed: 1,
			ans: '{i00: ONE, i01: 0, i10: 0, i11: ONE, d: 64'sh1_0000_0000,
			sing: 0, sat: 0}};
		directed.push_back(r);
		r = '{a: 0, b: 0, c: 0, d: 0, typed: 1,
			ans: '{i00: 0, i01: 0, i10: 0, i11: 0, d: 0, sing: 1, sat: 0}};
		directed.push_back(r);
		// singular, negating the most negative entry clamps
		r = '{a: 0, b: MOST_NEG, c: 0, d: 0, typed: 1,
			ans: '{i00: 0, i01: MOST_POS, i10: 0, i11: 0, d: 0, sing: 1, sat: 1}};
		directed.push_back(r);
		r = '{a: 0, b: 0, c: MOST_NEG, d: 0, typed: 1,
			ans: '{i00: 0, i01: 0, i10: MOST_POS, i11: 0, d: 0, sing: 1, sat: 1}};
		directed.push_back(r);
		r.typed = 0;
		r.a = MOST_NEG; r.b = MOST_NEG; r.c = MOST_NEG; r.d = MOST_NEG; directed.push_back(r);
		r.a = MOST_POS; r.b = MOST_POS; r.c = MOST_POS; r.d = MOST_POS; directed.push_back(r);
		r.a = MOST_NEG; r.b = MOST_POS; r.c = MOST_POS; r.d = MOST_NEG; directed.push_back(r);
		r.a = MOST_NEG; r.b = MOST_NEG; r.c = MOST_POS; r.d = MOST_NEG; directed.push_back(r);
		r.a = MOST_POS; r.b = MOST_NEG; r.c = MOST_NEG; r.d = MOST_POS; directed.push_back(r);
		// tiny determinant: quotients far out of range both ways
		r.a = 1; r.b = 0; r.c = 0; r.d = 1; directed.push_back(r);
		r.a = -1; r.b = 0; r.c = 0; r.d = 1; directed.push_back(r);
		r.a = MOST_POS; r.b = 0; r.c = 0; r.d = 1; directed.push_back(r);
		r.a = 2 * ONE; r.b = ONE; r.c = ONE; r.d = ONE; directed.push_back(r);
		r.a = -3 * ONE; r.b = 5 * ONE; r.c = 7 * ONE; r.d = -ONE; directed.push_back(r);
		r.a = 32'sh0000_8000; r.b = 0; r.c = 0; r.d = -32'sh0000_8000; directed.push_back(r);
		// quotient of exactly -2^31 does not clamp
		r.a = 1; r.b = 0; r.c = 0; r.d = -32'sh0000_0002; directed.push_back(r);
		r.a = ONE; r.b = 2 * ONE; r.c = 2 * ONE; r.d = 4 * ONE; directed.push_back(r);
		r.a = -1; r.b = -1; r.c = -1; r.d = -1; directed.push_back(r);
	end

	// sender: drive one item, hold until accepted, log what must come back
	task automatic send_matrix(logic signed [31:0] a, b, c, d, bit hold_off,
			int gap, bit typed, inverse_t ans);
		if (gap > 0 || (hold_off && pending_inverses.size() != 0)) begin
			in_valid <= 0;
			// wait out every outstanding result when asked
			while (hold_off && pending_inverses.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		m00 <= a;
		m01 <= b;
		m10 <= c;
		m11 <= d;
		do @(posedge clk); while (!(in_valid && in_ready));
		pending_inverses.push_back(typed ? ans : inverse_of(a, b, c, d));
	endtask

	initial begin
		logic signed [31:0] a, b, c, d, k;
		int busy_left;
		inverse_t none;
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		m00 = 0;
		m01 = 0;
		m10 = 0;
		m11 = 0;
		none = '{default: 0};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_matrix(directed[i].a, directed[i].b, directed[i].c, directed[i].d, 0,
				$urandom_range(0, 5), directed[i].typed, directed[i].ans);
		busy_left = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			// stretches with no gaps now and then
			if (n % 100 == 0)
				busy_left = ($urandom_range(0, 2) == 0) ? 100 : 0;
			case ($urandom_range(0, 3))
				0: begin
					// singular by construction: second row a multiple of the first
					a = $signed($urandom_range(0, 2000)) - 1000;
					b = $signed($urandom_range(0, 2000)) - 1000;
					k = $signed($urandom_range(0, 8)) - 4;
					c = a * k;
					d = b * k;
				end
				default: begin
					a = pick_entry();
					b = pick_entry();
					c = pick_entry();
					d = pick_entry();
				end
			endcase
			send_matrix(a, b, c, d, n == N_RANDOM / 2,
				busy_left > 0 ? 0 : $urandom_range(0, 5), 0, none);
			if (busy_left > 0)
				busy_left--;
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// receiver: random stalls per result, compare with the oldest expectation
	initial begin
		int stall;
		inverse_t e;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_inverses.size() == 0) begin
				$display("%0t: result with nothing expected, det %h", $time, det);
				errors++;
			end else begin
				e = pending_inverses.pop_front();
				if (inv00 !== e.i00) begin
					$display("%0t: inv00 expected %h got %h", $time, e.i00, inv00);
					errors++;
				end
				if (inv01 !== e.i01) begin
					$display("%0t: inv01 expected %h got %h", $time, e.i01, inv01);
					errors++;
				end
				if (inv10 !== e.i10) begin
					$display("%0t: inv10 expected %h got %h", $time, e.i10, inv10);
					errors++;
				end
				if (inv11 !== e.i11) begin
					$display("%0t: inv11 expected %h got %h", $time, e.i11, inv11);
					errors++;
				end
				if (det !== e.d) begin
					$display("%0t: det expected %h got %h", $time, e.d, det);
					errors++;
				end
				if (singular !== e.sing) begin
					$display("%0t: singular expected %b got %b", $time, e.sing, singular);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %b got %b", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	// end of run: drained, then a quiet spell to catch stray results
	initial begin
		wait (sending_done);
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// guard against a hung pipeline
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/mi2_pkg.sv
src/mi2_det.sv
src/mi2_div_step.sv
src/matrix_inverse_2x2_top.sv
src/mi2_checker.sv
sim/testbench.sv
